>>> design/pic80_pkg.sv
// ============================================================================
// pic80_pkg
// Shared types, constants and round functions of the Piccolo-80 cipher core.
// ============================================================================
package pic80_pkg;

    localparam int RC_W = 5;
    localparam logic [RC_W-1:0] RC_RESET = 5'd25;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUND_COUNT = 2'd0,
        CFG_KEY_LOW     = 2'd1,
        CFG_KEY_HIGH    = 2'd2
    } cfg_index_t;

    localparam logic KIND_DECRYPT = 1'b1;

    localparam logic [31:0] RK_MASK = 32'h0f1e2d3c;

    function automatic logic [3:0] sbox(input logic [3:0] a);
        logic [3:0] r;
        case (a)
            4'h0: r = 4'he;
            4'h1: r = 4'h4;
            4'h2: r = 4'hb;
            4'h3: r = 4'h2;
            4'h4: r = 4'h3;
            4'h5: r = 4'h8;
            4'h6: r = 4'h0;
            4'h7: r = 4'h9;
            4'h8: r = 4'h1;
            4'h9: r = 4'ha;
            4'ha: r = 4'h7;
            4'hb: r = 4'hf;
            4'hc: r = 4'h6;
            4'hd: r = 4'hc;
            4'he: r = 4'h5;
            default: r = 4'hd;
        endcase
        return r;
    endfunction

    // Multiply by x in GF(2^4) modulo x^4+x+1.
    function automatic logic [3:0] gmul2(input logic [3:0] a);
        return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
    endfunction

    function automatic logic [3:0] mix(input logic [3:0] a, input logic [3:0] b,
                                       input logic [3:0] c, input logic [3:0] d);
        return a ^ b ^ gmul2(c) ^ gmul2(d) ^ d;
    endfunction

    function automatic logic [15:0] ffun(input logic [15:0] x);
        logic [3:0] a0, a1, a2, a3;
        a0 = sbox(x[15:12]);
        a1 = sbox(x[11:8]);
        a2 = sbox(x[7:4]);
        a3 = sbox(x[3:0]);
        return {sbox(mix(a2, a3, a0, a1)), sbox(mix(a3, a0, a1, a2)),
                sbox(mix(a0, a1, a2, a3)), sbox(mix(a1, a2, a3, a0))};
    endfunction

    // Byte round permutation; word 0 sits in the top sixteen bits.
    function automatic logic [63:0] permute(input logic [63:0] w);
        return {w[47:40], w[7:0],
                w[31:24], w[55:48],
                w[15:8],  w[39:32],
                w[63:56], w[23:16]};
    endfunction

    // Key word j of the 80-bit key {k4, k3, k2, k1, k0}.
    function automatic logic [15:0] key_word(input logic [79:0] key, input int unsigned j);
        return key[16*j +: 16];
    endfunction

    // Round key of pair p; lo selects the second key of the pair.
    function automatic logic [15:0] round_key(input int unsigned p, input logic lo,
                                              input logic [79:0] key);
        logic [4:0]  c;
        logic [31:0] v;
        logic [15:0] kw;
        int unsigned m;
        c = 5'((p + 1) % 32);
        v = ({27'd0, c} << 27) | ({27'd0, c} << 17) | ({27'd0, c} << 10) | {27'd0, c};
        v = v ^ RK_MASK;
        m = p % 5;
        if (m == 0 || m == 2)
            kw = key_word(key, lo ? 3 : 2);
        else if (m == 3)
            kw = key_word(key, 4);
        else
            kw = key_word(key, lo ? 1 : 0);
        return (lo ? v[15:0] : v[31:16]) ^ kw;
    endfunction

    function automatic logic [15:0] whiten(input logic [79:0] key, input int unsigned n);
        logic [15:0] k0, k1, k3, k4, r;
        k0 = key_word(key, 0);
        k1 = key_word(key, 1);
        k3 = key_word(key, 3);
        k4 = key_word(key, 4);
        case (n)
            0: r = {k0[15:8], k1[7:0]};
            1: r = {k1[15:8], k0[7:0]};
            2: r = {k4[15:8], k3[7:0]};
            default: r = {k3[15:8], k4[7:0]};
        endcase
        return r;
    endfunction

endpackage

>>> design/piccolo80_block_cipher_top.sv
// ============================================================================
// piccolo80_block_cipher_top
// Piccolo-80 encrypt/decrypt core, one round per pipeline stage.
// ============================================================================
// The core takes one block word per cycle and returns one block word per cycle
// when the output side does not stall. Every word passes an input whitening
// stage and MAX_ROUNDS round stages, MAX_ROUNDS+1 register stages in all,
// so the path of each word from input to out_valid has the same length,
// independent of round_count; stages beyond the programmed round count pass
// the block through. Each stage holds its own valid bit and keeps moving into
// empty slots while the output is stalled.
// The key and round count must only be written while the core is empty.
module piccolo80_block_cipher_top
    import pic80_pkg::*;
#(
    parameter int MAX_ROUNDS = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [63:0]          block_in,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          block_out,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int NSTG = MAX_ROUNDS + 1;

    logic [RC_W-1:0] round_count_reg;
    logic [63:0]     key_low_reg;
    logic [15:0]     key_high_reg;
    logic [79:0]     key;
    logic [RC_W-1:0] last_round;

    logic [63:0]     blk_reg  [NSTG];
    logic [NSTG-1:0] kind_reg;
    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   go;

    assign cfg_ready = 1'b1;
    assign key       = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= RC_RESET;
            key_low_reg     <= '0;
            key_high_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROUND_COUNT: round_count_reg <= cfg_data[RC_W-1:0];
                CFG_KEY_LOW:     key_low_reg     <= cfg_data;
                CFG_KEY_HIGH:    key_high_reg    <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Index of the final round, with the count clamped to 1..MAX_ROUNDS.
    always_comb
    begin
        if (round_count_reg == '0)
            last_round = '0;
        else if (round_count_reg > RC_W'(MAX_ROUNDS))
            last_round = RC_W'(MAX_ROUNDS - 1);
        else
            last_round = round_count_reg - 1'b1;
    end

    // A stage may load when it is empty or its word moves on this cycle.
    assign go[NSTG] = !out_stall;
    for (genvar s = 0; s < NSTG; s++)
    begin : g_go
        assign go[s] = !valid_reg[s] || go[s+1];
    end

    assign in_stall  = !go[0];
    assign out_valid = valid_reg[NSTG-1];
    assign block_out = blk_reg[NSTG-1];

    // Input whitening stage.
    logic [63:0] wh_next;
    always_comb
    begin
        wh_next = block_in;
        if (kind == KIND_DECRYPT)
        begin
            wh_next[63:48] = block_in[63:48] ^ whiten(key, 2);
            wh_next[31:16] = block_in[31:16] ^ whiten(key, 3);
        end
        else
        begin
            wh_next[63:48] = block_in[63:48] ^ whiten(key, 0);
            wh_next[31:16] = block_in[31:16] ^ whiten(key, 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (go[0])
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (go[0] && in_valid)
        begin
            blk_reg[0]  <= wh_next;
            kind_reg[0] <= kind;
        end
    end

    // Round stages; stage r+1 performs round r.
    for (genvar r = 0; r < MAX_ROUNDS; r++)
    begin : g_round
        localparam int unsigned DP = MAX_ROUNDS - 1 - r;

        logic [63:0] w;
        logic        dec;
        logic [15:0] ka, kb;
        logic [15:0] t1, t3;
        logic [63:0] blk_next;

        assign w   = blk_reg[r];
        assign dec = (kind_reg[r] == KIND_DECRYPT);

        always_comb
        begin
            if (RC_W'(r) == last_round)
            begin
                ka = dec ? round_key(0, 1'b0, key) : round_key(MAX_ROUNDS - 1, 1'b0, key);
                kb = dec ? round_key(0, 1'b1, key) : round_key(MAX_ROUNDS - 1, 1'b1, key);
            end
            else if (dec)
            begin
                // Odd decrypt rounds use the two keys of the pair swapped.
                ka = round_key(DP, (r % 2) == 1, key);
                kb = round_key(DP, (r % 2) == 0, key);
            end
            else
            begin
                ka = round_key(r, 1'b0, key);
                kb = round_key(r, 1'b1, key);
            end

            t1 = w[47:32] ^ ffun(w[63:48]) ^ ka;
            t3 = w[15:0]  ^ ffun(w[31:16]) ^ kb;

            if (RC_W'(r) < last_round)
                blk_next = permute({w[63:48], t1, w[31:16], t3});
            else if (RC_W'(r) == last_round)
                blk_next = {w[63:48] ^ (dec ? whiten(key, 0) : whiten(key, 2)), t1,
                            w[31:16] ^ (dec ? whiten(key, 1) : whiten(key, 3)), t3};
            else
                blk_next = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[r+1] <= 1'b0;
            else if (go[r+1])
                valid_reg[r+1] <= valid_reg[r];
        end

        always_ff @(posedge clk)
        begin
            if (go[r+1] && valid_reg[r])
            begin
                blk_reg[r+1]  <= blk_next;
                kind_reg[r+1] <= kind_reg[r];
            end
        end
    end

endmodule

>>> test/tb_piccolo80_block_cipher_top.sv
// ============================================================================
// tb_piccolo80_block_cipher_top
// Self-checking bench for the Piccolo-80 encrypt/decrypt pipeline.
// A queue of pending blocks feeds a clocked driver. A clocked monitor checks
// every output word, in order, against a behavioral cipher model that runs
// from its own copy of the key and the round count. The run starts with
// directed blocks at the extreme keys and round counts. After that come
// randomly keyed phases under three sender/receiver idle patterns, with one
// long receiver hold-off that backs the pipeline up.
// ============================================================================
module tb_piccolo80_block_cipher_top
    import pic80_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NR = 25;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 114;
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    // S-box entry n sits in nibble n.
    localparam logic [63:0] SBOX_NIBBLES = 64'hd5c6f7a190832b4e;
    localparam logic [31:0] CON_MASK = 32'h0f1e2d3c;

    typedef struct packed {
        logic        kind;
        logic [63:0] block;
        logic [63:0] result;
    } cipher_job_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = 1'b0;
    logic [63:0]          block_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [63:0]          block_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    cipher_job_t blocks_to_send[$];
    cipher_job_t expected_blocks[$];
    cipher_job_t next_job;
    cipher_job_t accepted_job;
    cipher_job_t oldest_job;

    // Local copy of the programmed registers.
    logic [4:0]  cur_rounds = RC_RESET;
    logic [79:0] cur_key = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit burst_req = 1'b0;
    bit burst_done;
    int hold_left;
    int quiet_cycles;
    int mismatches = 0;

    piccolo80_block_cipher_top #(
        .MAX_ROUNDS(NR)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .block_out (block_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [3:0] sub_nibble(input logic [3:0] n);
        return SBOX_NIBBLES[4*n +: 4];
    endfunction

    function automatic logic [3:0] times_two(input logic [3:0] a);
        return {a[2:0], 1'b0} ^ {2'b00, a[3], a[3]};
    endfunction

    function automatic logic [15:0] f_box(input logic [15:0] x);
        logic [3:0][3:0] s;
        logic [15:0]     r;
        int              i;
        for (i = 0; i < 4; i++)
            s[i] = sub_nibble(x[15-4*i -: 4]);
        // Output nibble i is the S-box of 2*s[i] ^ 3*s[i+1] ^ s[i+2] ^ s[i+3], indexes mod 4.
        for (i = 0; i < 4; i++)
            r[15-4*i -: 4] = sub_nibble(times_two(s[i]) ^ times_two(s[(i+1)%4]) ^
                                        s[(i+1)%4] ^ s[(i+2)%4] ^ s[(i+3)%4]);
        return r;
    endfunction

    function automatic logic [15:0] key_slice(input logic [79:0] key, input int unsigned j);
        return key[16*j +: 16];
    endfunction

    function automatic logic [15:0] round_subkey(input int unsigned j, input logic [79:0] key);
        int unsigned pair;
        logic [4:0]  c;
        logic [31:0] con;
        logic [15:0] kw;
        pair = j / 2;
        c = 5'(pair + 1);
        con = {c, 5'b0, c, 2'b0, c, 5'b0, c} ^ CON_MASK;
        case (pair % 5)
            0, 2: kw = key_slice(key, j[0] ? 3 : 2);
            3: kw = key_slice(key, 4);
            default: kw = key_slice(key, j[0] ? 1 : 0);
        endcase
        return (j[0] ? con[15:0] : con[31:16]) ^ kw;
    endfunction

    function automatic logic [15:0] whitening_word(input int unsigned n, input logic [79:0] key);
        logic [15:0] k0, k1, k3, k4;
        k0 = key_slice(key, 0);
        k1 = key_slice(key, 1);
        k3 = key_slice(key, 3);
        k4 = key_slice(key, 4);
        case (n)
            0: return {k0[15:8], k1[7:0]};
            1: return {k1[15:8], k0[7:0]};
            2: return {k4[15:8], k3[7:0]};
            default: return {k3[15:8], k4[7:0]};
        endcase
    endfunction

    function automatic logic [63:0] piccolo_transform(input logic dec, input logic [63:0] blk,
                                                      input logic [4:0] rounds_reg,
                                                      input logic [79:0] key);
        logic [15:0] w0, w1, w2, w3, y0, y1, y2, y3;
        int unsigned n, i, ka, kb, t;
        n = (rounds_reg == 0) ? 1 : ((rounds_reg > NR) ? NR : rounds_reg);
        w0 = blk[63:48] ^ whitening_word(dec ? 2 : 0, key);
        w1 = blk[47:32];
        w2 = blk[31:16] ^ whitening_word(dec ? 3 : 1, key);
        w3 = blk[15:0];
        for (i = 0; i < n; i++)
        begin
            // The closing round always uses the outermost key pair.
            if (i == n - 1)
                ka = dec ? 0 : 2 * NR - 2;
            else if (!dec)
                ka = 2 * i;
            else
                ka = 2 * NR - 2 * i - 2;
            kb = ka + 1;
            if (dec && i != n - 1 && i % 2 == 1)
            begin
                t = ka;
                ka = kb;
                kb = t;
            end
            w1 = w1 ^ f_box(w0) ^ round_subkey(ka, key);
            w3 = w3 ^ f_box(w2) ^ round_subkey(kb, key);
            if (i != n - 1)
            begin
                y0 = {w1[15:8], w3[7:0]};
                y1 = {w2[15:8], w0[7:0]};
                y2 = {w3[15:8], w1[7:0]};
                y3 = {w0[15:8], w2[7:0]};
                w0 = y0;
                w1 = y1;
                w2 = y2;
                w3 = y3;
            end
        end
        w0 = w0 ^ whitening_word(dec ? 0 : 2, key);
        w2 = w2 ^ whitening_word(dec ? 1 : 3, key);
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [63:0] rand_block();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return {4{16'h5a5a ^ 16'(($urandom_range(1)) ? 16'hffff : 16'h0)}};
            3: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Input side: present the next pending word, hold it while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            block_in <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_job.kind = kind;
                accepted_job.block = block_in;
                accepted_job.result = piccolo_transform(kind, block_in, cur_rounds, cur_key);
                expected_blocks.push_back(accepted_job);
            end
            if (!in_valid || !in_stall)
            begin
                if (blocks_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_job = blocks_to_send.pop_front();
                    in_valid <= 1'b1;
                    kind <= next_job.kind;
                    block_in <= next_job.block;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: check each word, then choose the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            burst_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t ns: output word %h with none expected", $time, block_out);
                    mismatches++;
                end
                else
                begin
                    oldest_job = expected_blocks.pop_front();
                    if (block_out !== oldest_job.result)
                    begin
                        $display("%0t ns: %s of %h: expected %h, got %h", $time,
                                 (oldest_job.kind == KIND_DECRYPT) ? "decrypt" : "encrypt",
                                 oldest_job.block, oldest_job.result, block_out);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (burst_req && !burst_done)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                burst_done <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Must be entered right after a rising edge; returns at the edge that took the word.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROUND_COUNT: cur_rounds = data[4:0];
            CFG_KEY_LOW: cur_key[63:0] = data;
            CFG_KEY_HIGH: cur_key[79:64] = data[15:0];
            default: ;
        endcase
    endtask

    // Upper data bits are filled with noise; the core keeps only the register width.
    task automatic setup_cipher(input logic [4:0] rounds, input logic [79:0] key, input bit stray);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        @(posedge clk);
        write_register(CFG_ROUND_COUNT, {junk[63:5], rounds});
        if (stray)
            write_register(CFG_IDX_UNUSED, {$urandom, $urandom});
        write_register(CFG_KEY_LOW, key[63:0]);
        write_register(CFG_KEY_HIGH, {junk[47:0], key[79:64]});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (blocks_to_send.size() != 0 || in_valid || expected_blocks.size() != 0);
    endtask

    task automatic queue_block(input logic k, input logic [63:0] b);
        cipher_job_t job;
        job.kind = k;
        job.block = b;
        job.result = '0;
        blocks_to_send.push_back(job);
    endtask

    task automatic send_both(input logic [63:0] b);
        @(negedge clk);
        queue_block(KIND_ENCRYPT, b);
        queue_block(KIND_DECRYPT, b);
        wait_drained();
    endtask

    task automatic send_random(input int count, input int tx_pct, input int rx_pct, input bit hold);
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold)
            burst_req = 1'b1;
        repeat (count)
            queue_block(1'($urandom), rand_block());
        wait_drained();
    endtask

    task automatic random_setup();
        logic [4:0]  rounds;
        logic [79:0] key;
        // Mostly legal counts; now and then zero or a count from 26 to 31, above NR.
        if ($urandom_range(9) == 0)
            rounds = 5'($urandom_range(26, 32));
        else
            rounds = 5'($urandom_range(1, NR));
        case ($urandom_range(7))
            0: key = '0;
            1: key = '1;
            default: key = {16'($urandom), $urandom, $urandom};
        endcase
        setup_cipher(rounds, key, $urandom_range(3) == 0);
    endtask

    initial
    begin
        tx_idle_pct = 11;
        rx_idle_pct = 65;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: full rounds, all-zero key.
        send_both('0);
        send_both('1);

        setup_cipher(5'd25, '1, 1'b0);
        send_both(64'h0123456789abcdef);
        send_both(64'h8000000000000001);

        // Zero rounds acts as one, large counts saturate at the pipeline depth.
        setup_cipher(5'd0, {16'($urandom), $urandom, $urandom}, 1'b0);
        send_both({$urandom, $urandom});
        setup_cipher(5'd1, cur_key, 1'b0);
        send_both({$urandom, $urandom});
        setup_cipher(5'd31, cur_key, 1'b0);
        send_both({$urandom, $urandom});
        setup_cipher(5'd26, cur_key, 1'b0);
        send_both({$urandom, $urandom});
        setup_cipher(5'd24, {16'($urandom), $urandom, $urandom}, 1'b1);
        send_both({$urandom, $urandom});

        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            send_random(PHASE_ITEMS, 11, 65, 1'b0);
        end
        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            send_random(PHASE_ITEMS, 65, 11, 1'b0);
        end
        for (int p = 0; p < 3; p++)
        begin
            random_setup();
            send_random(PHASE_ITEMS, 0, 0, p == 0);
        end

        repeat (NR + 8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/pic80_pkg.sv
design/piccolo80_block_cipher_top.sv
test/tb_piccolo80_block_cipher_top.sv
